/* hw/rtl/ffc_pkg.sv */
// shared types, mode codes and conversion functions for the float format converter
package ffc_pkg;

    typedef logic [31:0] word_t;
    typedef logic [1:0]  mode_t;

    localparam mode_t MODE_F32_F16  = 2'd0;
    localparam mode_t MODE_F32_BF16 = 2'd1;
    localparam mode_t MODE_F16_F32  = 2'd2;
    localparam mode_t MODE_BF16_F32 = 2'd3;

    function automatic logic [15:0] f32_to_f16(input word_t x);
        logic        s;
        logic [7:0]  e;
        logic [22:0] m;
        logic [15:0] v;
        logic [24:0] sig;
        logic [24:0] rem;
        logic [24:0] half;
        logic [12:0] rem13;
        logic [4:0]  sh;
        logic        up;
        s    = x[31];
        e    = x[30:23];
        m    = x[22:0];
        sig  = {2'b01, m};
        sh   = 5'(8'd126 - e);
        v    = '0;
        up   = 1'b0;
        rem  = '0;
        half = '0;
        rem13 = m[12:0];
        if (e == 8'hff) begin
            f32_to_f16 = (m != '0) ? {s, 15'h7e00} : {s, 15'h7c00};
        end else if (e >= 8'd143) begin
            f32_to_f16 = {s, 15'h7c00};
        end else if (e >= 8'd113) begin
            v  = {1'b0, 5'(e - 8'd112), m[22:13]};
            up = (rem13 > 13'h1000) || (rem13 == 13'h1000 && v[0]);
            f32_to_f16 = {s, 15'(v + 16'(up))};
        end else if (e < 8'd102) begin
            f32_to_f16 = {s, 15'h0};
        end else begin
            v    = 16'(sig >> sh);
            rem  = sig & ((25'd1 << sh) - 25'd1);
            half = 25'd1 << (sh - 5'd1);
            up   = (rem > half) || (rem == half && v[0]);
            f32_to_f16 = {s, 15'(v + 16'(up))};
        end
    endfunction

    function automatic logic [15:0] f32_to_bf16(input word_t x);
        logic [32:0] t;
        t = {1'b0, x};
        if (x[30:23] == 8'hff) begin
            if (x[15:0] != '0) begin
                t[16] = 1'b1;
            end
        end else begin
            t = t + 33'h7fff + 33'(x[16]);
        end
        f32_to_bf16 = t[31:16];
    endfunction

    function automatic word_t f16_to_f32(input logic [15:0] h);
        logic [4:0] e;
        logic [9:0] m;
        logic [3:0] k;
        logic [9:0] nm;
        e  = h[14:10];
        m  = h[9:0];
        k  = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) begin
                k = 4'(i);
            end
        end
        nm = m << (4'd10 - k);
        if (e == 5'd31) begin
            f16_to_f32 = {h[15], 8'hff, m, 13'h0};
        end else if (e == 5'd0) begin
            if (m == '0) begin
                f16_to_f32 = {h[15], 31'h0};
            end else begin
                f16_to_f32 = {h[15], 8'(8'd103 + 8'(k)), nm, 13'h0};
            end
        end else begin
            f16_to_f32 = {h[15], 8'(8'd112 + 8'(e)), m, 13'h0};
        end
    endfunction

endpackage

/* hw/rtl/ffc_core.sv */
// conversion datapath selecting one of the four casts
module ffc_core (
    input  ffc_pkg::mode_t mode,
    input  ffc_pkg::word_t in_bits,
    output ffc_pkg::word_t out_bits
);
    import ffc_pkg::*;

    always_comb begin
        unique case (mode)
            MODE_F32_F16:  out_bits = {16'h0, f32_to_f16(in_bits)};
            MODE_F32_BF16: out_bits = {16'h0, f32_to_bf16(in_bits)};
            MODE_F16_F32:  out_bits = f16_to_f32(in_bits[15:0]);
            MODE_BF16_F32: out_bits = {in_bits[15:0], 16'h0};
            default:       out_bits = '0;
        endcase
    end
endmodule

/* hw/rtl/float_format_converter_unit.sv */
// top level of the float format converter: input register, cast, result register
//   channel | ports                      | contents
//   s_      | s_tvalid s_tready s_tdata  | in_bits, s_tlast in_last
//   m_      | m_tvalid m_tready m_tdata  | out_bits, m_tlast out_last
//   cfg     | cfg_wr_en cfg_wr_data      | conversion_mode
// one request per cycle unless a low m_tready stalls the result register
// stages: input register, cast logic, result register
// a stage advances when it is empty or the one after it moves
// aresetn clears valid flags and the mode register (mode 0)
module float_format_converter_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  ffc_pkg::mode_t      cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  ffc_pkg::word_t      s_tdata,   // in_bits
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output ffc_pkg::word_t      m_tdata,   // out_bits
    output logic                m_tlast
);
    import ffc_pkg::*;

    mode_t mode_reg;
    logic  in_valid_reg, out_valid_reg;
    word_t in_data_reg, out_data_reg;
    logic  in_last_reg, out_last_reg;
    word_t out_data_next;
    logic  out_adv, in_adv;

    assign out_adv  = !out_valid_reg || m_tready;
    assign in_adv   = !in_valid_reg || out_adv;
    assign s_tready = in_adv;

    ffc_core u_core (
        .mode     (mode_reg),
        .in_bits  (in_data_reg),
        .out_bits (out_data_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_F32_F16;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (in_adv) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_adv) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (out_adv && in_valid_reg) begin
            out_data_reg <= out_data_next;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
endmodule
